FILE: src/lgps_pkg.sv
package lgps_pkg;

	localparam int MAX_STOPS_DEF  = 8;
	localparam int COORD_BITS_DEF = 13;
	localparam int ADDR_W         = 5;
	localparam int COORD_W        = 13;

	localparam logic [16:0] UNIT_ONE = 17'h10000;

	typedef enum logic [2:0] {
		REG_COEF_X      = 3'd0,
		REG_COEF_Y      = 3'd1,
		REG_COEF_OFFSET = 3'd2,
		REG_TILE_MODE   = 3'd3,
		REG_STOP_COUNT  = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		TILE_CLAMP  = 2'd0,
		TILE_REPEAT = 2'd1,
		TILE_MIRROR = 2'd2
	} tile_mode_t;

	typedef enum logic {
		OP_SHADE = 1'b0,
		OP_LOAD  = 1'b1
	} op_t;

endpackage

FILE: src/lgps_if.sv
interface lgps_item_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [12:0] pixel_x;
	logic [12:0] pixel_y;
	logic        span_end;
	logic [2:0]  stop_index;
	logic [7:0]  stop_alpha;
	logic [7:0]  stop_red;
	logic [7:0]  stop_green;
	logic [7:0]  stop_blue;

	modport source (output valid, operation, pixel_x, pixel_y, span_end, stop_index,
		stop_alpha, stop_red, stop_green, stop_blue, input ready);
	modport sink (input valid, operation, pixel_x, pixel_y, span_end, stop_index,
		stop_alpha, stop_red, stop_green, stop_blue, output ready);
endinterface

interface lgps_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_alpha;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       last_of_span;

	modport source (output valid, out_alpha, out_red, out_green, out_blue, last_of_span,
		input ready);
	modport sink (input valid, out_alpha, out_red, out_green, out_blue, last_of_span,
		output ready);
endinterface

FILE: src/linear_gradient_pixel_shader_top.sv
// Channel  | Kind   | Beat carries
// item     | sink   | operation, pixel x/y, span end, stop index and stop color
// result   | source | premultiplied ARGB pixel and last_of_span
// APB      | slave  | coef_x, coef_y, coef_offset, tile_mode, stop_count
// One beat is taken every cycle unless a stalled result holds the whole pipeline.
// A shade beat passes the six-stage pipeline: coefficient multiply, sum and tiling,
// stop selection with the stop RAM read, channel blend, premultiply, rounding divide.
// A stop load is written into the RAM when it leaves stage two and gives no result.
// arst_n clears the coefficients, tile mode and valid bits and sets stop_count to 2.
// Stop colors are undefined until loaded; item.ready is low only while a result stalls.
module linear_gradient_pixel_shader_top #(
	parameter int MAX_STOPS  = lgps_pkg::MAX_STOPS_DEF,
	parameter int COORD_BITS = lgps_pkg::COORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lgps_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	lgps_item_if.sink                   item,
	lgps_result_if.source               result
);

	localparam int IW = $clog2(MAX_STOPS);
	localparam logic [12:0] CMASK = 13'((64'd1 << COORD_BITS) - 64'd1);
	localparam logic [48:0] HALF_DIV = 49'(64'd255 << 31);

	logic signed [31:0] coef_x_q, coef_y_q, coef_offset_q;
	logic [1:0]         tile_mode_q;
	logic [3:0]         stop_count_q;
	logic               cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_x_q      <= '0;
			coef_y_q      <= '0;
			coef_offset_q <= '0;
			tile_mode_q   <= lgps_pkg::TILE_CLAMP;
			stop_count_q  <= 4'd2;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				lgps_pkg::REG_COEF_X:      coef_x_q      <= pwdata;
				lgps_pkg::REG_COEF_Y:      coef_y_q      <= pwdata;
				lgps_pkg::REG_COEF_OFFSET: coef_offset_q <= pwdata;
				lgps_pkg::REG_TILE_MODE:   tile_mode_q   <= pwdata[1:0];
				lgps_pkg::REG_STOP_COUNT:  stop_count_q  <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			lgps_pkg::REG_COEF_X:      prdata = coef_x_q;
			lgps_pkg::REG_COEF_Y:      prdata = coef_y_q;
			lgps_pkg::REG_COEF_OFFSET: prdata = coef_offset_q;
			lgps_pkg::REG_TILE_MODE:   prdata = {30'd0, tile_mode_q};
			lgps_pkg::REG_STOP_COUNT:  prdata = {28'd0, stop_count_q};
			default:                   prdata = '0;
		endcase
	end

	logic en, take;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	assign en         = !v_s6 || result.ready;
	assign item.ready = en;
	assign take       = item.valid && en;

	// Stage 1: both coefficient products.
	logic signed [14:0] mx, my;
	logic signed [46:0] prod_x_s1, prod_y_s1;
	logic               op_s1, last_s1;
	logic [2:0]         si_s1;
	logic [31:0]        color_s1;

	assign mx = {1'b0, item.pixel_x & CMASK, 1'b1};
	assign my = {1'b0, item.pixel_y & CMASK, 1'b1};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_x_s1 <= coef_x_q * mx;
			prod_y_s1 <= coef_y_q * my;
			op_s1     <= item.operation;
			last_s1   <= item.span_end;
			si_s1     <= item.stop_index;
			color_s1  <= {item.stop_alpha, item.stop_red, item.stop_green, item.stop_blue};
		end
	end

	// Stage 2: sum, floor halve and tile.
	logic signed [48:0] big;
	logic signed [47:0] tpar;
	logic [16:0]        mir, u_c, u_s2;
	logic               op_s2, last_s2;
	logic [2:0]         si_s2;
	logic [31:0]        color_s2;

	always_comb begin
		big  = 49'(prod_x_s1) + 49'(prod_y_s1) + 49'(signed'({coef_offset_q, 1'b0}));
		tpar = big[48:1];
		mir  = tpar[16:0];
		unique case (tile_mode_q)
			lgps_pkg::TILE_REPEAT: u_c = {1'b0, tpar[15:0]};
			lgps_pkg::TILE_MIRROR:
				u_c = (mir > lgps_pkg::UNIT_ONE) ? 17'(18'h20000 - {1'b0, mir}) : mir;
			default: begin
				if (tpar < 0)
					u_c = '0;
				else if (tpar > 48'sd65536)
					u_c = lgps_pkg::UNIT_ONE;
				else
					u_c = tpar[16:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s2     <= u_c;
			op_s2    <= op_s1;
			last_s2  <= last_s1;
			si_s2    <= si_s1;
			color_s2 <= color_s1;
		end
	end

	// Stage 3: stop pair and weight; stop loads are written here.
	int            n_i;
	logic [IW-1:0] nm1, i1, i2;
	logic [IW:0]   nm1x, idx, idx1;
	logic [16+IW:0] sprod;
	logic [15:0]   f_c, f_s3;
	logic          last_s3, ram_we, ram_re;
	logic [31:0]   c1, c2;

	always_comb begin
		if (stop_count_q == 4'd0)
			n_i = 1;
		else if (int'(stop_count_q) > MAX_STOPS)
			n_i = MAX_STOPS;
		else
			n_i = int'(stop_count_q);
		nm1   = IW'(n_i - 1);
		nm1x  = (IW+1)'(nm1);
		sprod = (17+IW)'(u_s2) * (17+IW)'(nm1);
		idx   = sprod[16+IW:16];
		idx1  = idx + (IW+1)'(1);
		i1    = (idx < nm1x) ? idx[IW-1:0] : nm1;
		i2    = (idx1 < nm1x) ? idx1[IW-1:0] : nm1;
		f_c   = (idx >= nm1x) ? 16'd0 : sprod[15:0];
	end

	assign ram_we = en && v_s2 && op_s2 && (int'(si_s2) < MAX_STOPS);
	assign ram_re = en && v_s2 && !op_s2;

	lgps_ram #(.WIDTH(32), .DEPTH(MAX_STOPS)) u_stop_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (IW'(si_s2)),
		.wdata   (color_s2),
		.re      (ram_re),
		.raddr_a (i1),
		.raddr_b (i2),
		.rdata_a (c1),
		.rdata_b (c2)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			f_s3    <= f_c;
			last_s3 <= last_s2;
		end
	end

	// Stage 4: per-channel blend, byte 3 alpha down to byte 0 blue.
	logic [16:0] wf;
	logic [23:0] cc_c [4];
	logic [23:0] cc_s4 [4];
	logic        last_s4;

	always_comb begin
		wf = lgps_pkg::UNIT_ONE - {1'b0, f_s3};
		for (int k = 0; k < 4; k++) begin
			cc_c[k] = 24'(25'(c1[8*k +: 8]) * 25'(wf) + 25'(c2[8*k +: 8]) * 25'(f_s3));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s4   <= cc_c;
			last_s4 <= last_s3;
		end
	end

	// Stage 5: alpha rounding and premultiply products.
	logic [24:0] a_round;
	logic [7:0]  alpha_s5;
	logic [47:0] prod_s5 [3];
	logic        last_s5;

	assign a_round = 25'(cc_s4[3]) + 25'd32768;

	always_ff @(posedge clk) begin
		if (en) begin
			alpha_s5 <= a_round[23:16];
			for (int k = 0; k < 3; k++) begin
				prod_s5[k] <= 48'(cc_s4[k]) * 48'(cc_s4[3]);
			end
			last_s5 <= last_s4;
		end
	end

	// Stage 6: rounded divide by 255 * 2^32.
	logic [48:0] xsum [3];
	logic [16:0] ydiv [3];
	logic [17:0] qdiv [3];
	logic [7:0]  chan_s6 [3];
	logic [7:0]  alpha_s6;
	logic        last_s6;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			xsum[k] = 49'(prod_s5[k]) + HALF_DIV;
			ydiv[k] = xsum[k][48:32];
			qdiv[k] = (18'(ydiv[k]) + 18'd1 + 18'(ydiv[k] >> 8)) >> 8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				chan_s6[k] <= qdiv[k][7:0];
			end
			alpha_s6 <= alpha_s5;
			last_s6  <= last_s5;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2 && !op_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	assign result.valid        = v_s6;
	assign result.out_alpha    = alpha_s6;
	assign result.out_red      = chan_s6[2];
	assign result.out_green    = chan_s6[1];
	assign result.out_blue     = chan_s6[0];
	assign result.last_of_span = last_s6;

endmodule

FILE: src/lgps_ram.sv
module lgps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

FILE: src/lgps_checker.sv
module lgps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [32:0] out_payload,
	input logic        psel,
	input logic        pready
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result beat changed while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("item refused with an empty output stage");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while the pipeline is held");

	assert property (@(posedge clk) disable iff (!arst_n)
		psel |-> pready)
		else $error("register access was not completed");

endmodule

bind linear_gradient_pixel_shader_top lgps_checker u_lgps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (item.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.out_payload ({result.out_alpha, result.out_red, result.out_green, result.out_blue,
		result.last_of_span}),
	.psel        (psel),
	.pready      (pready)
);
